// ===== sv/bis_pkg.sv =====
// Shared types and constants for the bilinear sample and splat block.
package bis_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_COLOR_BITS = 16;

    localparam int IN_COLOR_W = 16;
    localparam int SIZE_W     = 13;
    localparam int CFG_W      = 9;
    localparam int WGT_W      = 17;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_SPLAT  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_ACC,
        ST_OUT
    } back_state_t;

endpackage

// ===== sv/bis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bis_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 65536,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bis_queue.sv =====
// Two-entry register queue between the front end and the back end.
module bis_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== sv/bis_front.sv =====
// Front end: configuration registers, beat decode, neighbor addresses and weights.
module bis_front import bis_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int AW         = 16,
    parameter int ENT_W      = 186
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [127:0]     s_tdata,
    input  logic [1:0]       s_tuser,
    input  logic             clearing,
    output logic             q_valid,
    input  logic             q_ready,
    output logic [ENT_W-1:0] q_data
);

    logic [CFG_W-1:0]  width_reg, width_next;
    logic [CFG_W-1:0]  height_reg, height_next;
    logic [SIZE_W-1:0] w_eff, h_eff;

    op_t               op;
    logic [7:0]        pixel_col, pixel_row;
    logic [15:0]       red_in, green_in, blue_in;
    logic [15:0]       sample_u, sample_v, splat_x, splat_y;

    logic [SIZE_W+15:0] xs, ys;
    logic [SIZE_W-1:0]  c0, r0, c0p, r0p, c1, r1;
    logic [16:0]        sxr, syr;
    logic [8:0]         ix, iy, swx0, swy0;
    logic [17:0]        tx, ty;

    logic [SIZE_W-1:0]  col_a [2];
    logic [SIZE_W-1:0]  row_a [2];
    logic [WGT_W-1:0]   wx [2];
    logic [WGT_W-1:0]   wy [2];
    logic [3:0]         mask;
    logic [AW-1:0]      addr [4];

    assign op        = op_t'(s_tuser);
    assign pixel_col = s_tdata[7:0];
    assign pixel_row = s_tdata[15:8];
    assign red_in    = s_tdata[31:16];
    assign green_in  = s_tdata[47:32];
    assign blue_in   = s_tdata[63:48];
    assign sample_u  = s_tdata[79:64];
    assign sample_v  = s_tdata[95:80];
    assign splat_x   = s_tdata[111:96];
    assign splat_y   = s_tdata[127:112];

    always_comb begin
        if (width_reg == '0) begin
            w_eff = SIZE_W'(1);
        end else if (SIZE_W'(width_reg) > SIZE_W'(MAX_WIDTH)) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            w_eff = SIZE_W'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = SIZE_W'(1);
        end else if (SIZE_W'(height_reg) > SIZE_W'(MAX_HEIGHT)) begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end else begin
            h_eff = SIZE_W'(height_reg);
        end
    end

    always_comb begin
        xs  = (SIZE_W+16)'(sample_u) * (SIZE_W+16)'(w_eff);
        ys  = (SIZE_W+16)'(sample_v) * (SIZE_W+16)'(h_eff);
        c0  = xs[SIZE_W+15:16];
        r0  = ys[SIZE_W+15:16];
        c0p = c0 + SIZE_W'(1);
        r0p = r0 + SIZE_W'(1);
        c1  = (c0p >= w_eff) ? '0 : c0p;
        r1  = (r0p >= h_eff) ? '0 : r0p;

        sxr  = 17'(splat_x) + 17'd128;
        syr  = 17'(splat_y) + 17'd128;
        ix   = sxr[16:8];
        iy   = syr[16:8];
        tx   = {1'b0, ix, 8'd0} + 18'd128 - 18'(splat_x);
        ty   = {1'b0, iy, 8'd0} + 18'd128 - 18'(splat_y);
        swx0 = tx[8:0];
        swy0 = ty[8:0];

        col_a[0] = '0;
        col_a[1] = '0;
        row_a[0] = '0;
        row_a[1] = '0;
        wx[0]    = '0;
        wx[1]    = '0;
        wy[0]    = '0;
        wy[1]    = '0;
        mask     = '0;
        case (op)
            OP_WRITE: begin
                col_a[0] = SIZE_W'(pixel_col);
                row_a[0] = SIZE_W'(pixel_row);
                mask[0]  = (SIZE_W'(pixel_col) < w_eff) && (SIZE_W'(pixel_row) < h_eff);
            end
            OP_SAMPLE: begin
                col_a[0] = c0;
                col_a[1] = c1;
                row_a[0] = r0;
                row_a[1] = r1;
                wx[0]    = 17'h10000 - 17'(xs[15:0]);
                wx[1]    = 17'(xs[15:0]);
                wy[0]    = 17'h10000 - 17'(ys[15:0]);
                wy[1]    = 17'(ys[15:0]);
                mask     = 4'hF;
            end
            OP_SPLAT: begin
                col_a[0] = SIZE_W'(ix) - SIZE_W'(1);
                col_a[1] = SIZE_W'(ix);
                row_a[0] = SIZE_W'(iy) - SIZE_W'(1);
                row_a[1] = SIZE_W'(iy);
                wx[0]    = 17'(swx0);
                wx[1]    = 17'd256 - 17'(swx0);
                wy[0]    = 17'(swy0);
                wy[1]    = 17'd256 - 17'(swy0);
                for (int n = 0; n < 4; n++) begin
                    mask[n] = (ix != '0 || n[0]) && (iy != '0 || n[1])
                        && (col_a[n % 2] < w_eff) && (row_a[n / 2] < h_eff);
                end
            end
            default: begin
                mask = '0;
            end
        endcase

        for (int n = 0; n < 4; n++) begin
            addr[n] = AW'(32'(row_a[n / 2]) * MAX_WIDTH + 32'(col_a[n % 2]));
        end
    end

    assign q_data = {2'(op), mask, addr[3], addr[2], addr[1], addr[0],
                     wy[1], wy[0], wx[1], wx[0], blue_in, green_in, red_in};
    assign q_valid  = s_tvalid && !clearing;
    assign s_tready = q_ready && !clearing;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:  width_next  = cfg_wdata;
                REG_IMAGE_HEIGHT: height_next = cfg_wdata;
                default: begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(256);
            height_reg <= CFG_W'(256);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

endmodule

// ===== sv/bis_back.sv =====
// Back end: store clearing, pixel writes, bilinear blend and splat read-modify-write.
module bis_back import bis_pkg::*; #(
    parameter int COLOR_BITS = DEF_COLOR_BITS,
    parameter int AW         = 16,
    parameter int DEPTH      = 65536,
    parameter int ENT_W      = 186
) (
    input  logic             aclk,
    input  logic             aresetn,
    output logic             clearing,
    input  logic             q_valid,
    output logic             q_ready,
    input  logic [ENT_W-1:0] q_data,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata
);

    localparam int CB     = COLOR_BITS;
    localparam int MUL_W  = (CB > IN_COLOR_W) ? CB : IN_COLOR_W;
    localparam int M1_W   = MUL_W + WGT_W;
    localparam int M2_W   = MUL_W + 2 * WGT_W;
    localparam int SUM_W  = M2_W + 1;
    localparam int TOT_W  = SUM_W - 15;
    localparam int ACC_W  = (CB + 32 > 48) ? CB + 32 : 48;
    localparam logic [CB-1:0] CMAX = '1;

    back_state_t      st_reg, st_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [1:0]       n_reg, n_next;
    logic [ENT_W-1:0] ent_reg, ent_next;
    logic [3*CB-1:0]  pix_reg, pix_next;
    logic [M1_W-1:0]  m1_reg [3];
    logic [M1_W-1:0]  m1_next [3];
    logic [M2_W-1:0]  m2_reg [3];
    logic [M2_W-1:0]  m2_next [3];
    logic [ACC_W-1:0] acc_reg [3];
    logic [ACC_W-1:0] acc_next [3];
    logic             m_tvalid_reg, m_tvalid_next;
    logic [47:0]      out_reg, out_next;

    logic [ENT_W-1:0] e;
    op_t              e_op;
    logic [3:0]       e_mask;
    logic [AW-1:0]    e_addr [4];
    logic [WGT_W-1:0] e_wx [2];
    logic [WGT_W-1:0] e_wy [2];
    logic [15:0]      e_color [3];

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [3*CB-1:0]  ram_wdata, ram_rdata;

    assign e      = (st_reg == ST_IDLE) ? q_data : ent_reg;
    assign e_op   = op_t'(e[ENT_W-1 -: 2]);
    assign e_mask = e[ENT_W-3 -: 4];
    always_comb begin
        for (int n = 0; n < 4; n++) begin
            e_addr[n] = e[48 + 4 * WGT_W + n * AW +: AW];
        end
        for (int i = 0; i < 2; i++) begin
            e_wx[i] = e[48 + i * WGT_W +: WGT_W];
            e_wy[i] = e[48 + (2 + i) * WGT_W +: WGT_W];
        end
        for (int k = 0; k < 3; k++) begin
            e_color[k] = e[k * 16 +: 16];
        end
    end

    assign clearing = (st_reg == ST_CLEAR);
    assign q_ready  = (st_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    always_comb begin
        logic [MUL_W-1:0]  opnd;
        logic [SUM_W-1:0]  rsum;
        logic [TOT_W-1:0]  tot;
        logic [ACC_W-1:0]  rnd;
        logic              last;

        opnd          = '0;
        rsum          = '0;
        tot           = '0;
        rnd           = '0;
        st_next       = st_reg;
        clr_next      = clr_reg;
        n_next        = n_reg;
        ent_next      = ent_reg;
        pix_next      = pix_reg;
        m1_next       = m1_reg;
        m2_next       = m2_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_next      = out_reg;
        ram_we        = 1'b0;
        ram_waddr     = e_addr[n_reg];
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = e_addr[n_reg];
        last          = (n_reg == 2'd3);

        case (st_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    ent_next = q_data;
                    n_next   = 2'd0;
                    for (int k = 0; k < 3; k++) begin
                        acc_next[k] = '0;
                        if (MUL_W'(e_color[k]) > MUL_W'(CMAX)) begin
                            ram_wdata[k * CB +: CB] = CMAX;
                        end else begin
                            ram_wdata[k * CB +: CB] = CB'(e_color[k]);
                        end
                    end
                    ram_waddr = e_addr[0];
                    case (e_op)
                        OP_WRITE:  ram_we  = e_mask[0];
                        OP_SAMPLE: st_next = ST_READ;
                        OP_SPLAT:  st_next = ST_READ;
                        default:   st_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                if (e_mask[n_reg]) begin
                    ram_re  = 1'b1;
                    st_next = ST_MUL1;
                end else if (last) begin
                    st_next = (e_op == OP_SAMPLE) ? ST_OUT : ST_IDLE;
                end else begin
                    n_next = n_reg + 2'd1;
                end
            end
            ST_MUL1: begin
                pix_next = ram_rdata;
                for (int k = 0; k < 3; k++) begin
                    opnd = (e_op == OP_SAMPLE) ? MUL_W'(ram_rdata[k * CB +: CB])
                                               : MUL_W'(e_color[k]);
                    m1_next[k] = M1_W'(opnd) * M1_W'(e_wx[n_reg[0]]);
                end
                st_next = ST_MUL2;
            end
            ST_MUL2: begin
                for (int k = 0; k < 3; k++) begin
                    m2_next[k] = M2_W'(m1_reg[k]) * M2_W'(e_wy[n_reg[1]]);
                end
                st_next = ST_ACC;
            end
            ST_ACC: begin
                for (int k = 0; k < 3; k++) begin
                    if (e_op == OP_SAMPLE) begin
                        acc_next[k] = acc_reg[k] + ACC_W'(m2_reg[k]);
                    end else begin
                        rsum = SUM_W'(m2_reg[k]) + SUM_W'(32768);
                        tot  = TOT_W'(pix_reg[k * CB +: CB]) + TOT_W'(rsum[SUM_W-1:16]);
                        if (tot > TOT_W'(CMAX)) begin
                            ram_wdata[k * CB +: CB] = CMAX;
                        end else begin
                            ram_wdata[k * CB +: CB] = CB'(tot);
                        end
                    end
                end
                ram_we = (e_op == OP_SPLAT);
                if (last) begin
                    st_next = (e_op == OP_SAMPLE) ? ST_OUT : ST_IDLE;
                end else begin
                    n_next  = n_reg + 2'd1;
                    st_next = ST_READ;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    for (int k = 0; k < 3; k++) begin
                        rnd = acc_reg[k] + ACC_W'(64'h8000_0000);
                        out_next[k * 16 +: 16] = rnd[32 +: 16];
                    end
                    m_tvalid_next = 1'b1;
                    st_next       = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_CLEAR;
            clr_reg      <= '0;
            n_reg        <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            clr_reg      <= clr_next;
            n_reg        <= n_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
        pix_reg <= pix_next;
        m1_reg  <= m1_next;
        m2_reg  <= m2_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    bis_ram #(
        .WIDTH (3 * CB),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    a_acc_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_ACC) |-> ($past(st_reg) == ST_MUL2))
        else $error("accumulate step without product");

    a_mul_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_MUL1) |-> $past(ram_re))
        else $error("product step without store read");

    a_out_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_OUT && (!m_tvalid_reg || m_tready)) |=>
            (m_tvalid_reg && st_reg == ST_IDLE))
        else $error("sample result not presented");

    a_clear_no_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_CLEAR) |-> (ram_we && ram_wdata == '0 && !ram_re))
        else $error("store access during clearing");

endmodule

// ===== sv/bilinear_image_sample_splat_top.sv =====
// Bilinear sampler and area splatter over an RGB pixel store.
// After reset the store is cleared one pixel per cycle, all MAX_WIDTH * MAX_HEIGHT
// pixels (65536 by default), and no beat is taken meanwhile; configuration
// writes are taken at any time. A pixel write is done by the back end as it
// takes the entry. A sample takes the beat, then per neighbor does one read,
// two multiply steps and one accumulate, and then loads the result register.
// A splat takes the beat, then for each of up to four neighbors does one read,
// two multiply steps and one write back if that neighbor is in bound, and
// skips it otherwise. A two-beat queue lets the input side run ahead; the
// result register holds one finished sample while the output side stalls,
// and a further sample then waits in the back end until that register is free.
module bilinear_image_sample_splat_top import bis_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int COLOR_BITS = DEF_COLOR_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // pixel_col, pixel_row, red_in, green_in, blue_in, sample_u, sample_v,
    // splat_x, splat_y
    input  logic [127:0]     s_tdata,
    // operation
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // red_out, green_out, blue_out
    output logic [47:0]      m_tdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int ENT_W = 48 + 4 * WGT_W + 4 * AW + 6;

    logic             clearing;
    logic             q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    logic [ENT_W-1:0] q_in_data, q_out_data;

    bis_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW),
        .ENT_W      (ENT_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clearing  (clearing),
        .q_valid   (q_in_valid),
        .q_ready   (q_in_ready),
        .q_data    (q_in_data)
    );

    bis_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    bis_back #(
        .COLOR_BITS (COLOR_BITS),
        .AW         (AW),
        .DEPTH      (DEPTH),
        .ENT_W      (ENT_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clearing (clearing),
        .q_valid  (q_out_valid),
        .q_ready  (q_out_ready),
        .q_data   (q_out_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
